// File: rtl/pcmp_pkg.sv
// shared constants, types and register codes for the partition number generator
// no dependencies
package pcmp_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int OFS_W       = CNT_W + 1;
   localparam int KK_W        = ADDR_W / 2 + 2;
   localparam int DATA_W      = 32;
   localparam int LEN_W       = 11;
   localparam int IDX_W       = 10;
   localparam int CSR_IDX_W   = 1;
   localparam int REM_CNT_W   = $clog2(DATA_W);

   localparam logic [DATA_W-1:0] DEFAULT_MODULUS = 32'd1000000007;

   localparam logic [CSR_IDX_W-1:0] CSR_MODULUS      = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_LENGTH = 1'd1;

   localparam logic [LEN_W-1:0] TABLE_LENGTH_RESET = 11'd1024;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_RUN  = 4'b0010,
      ST_REM  = 4'b0100,
      ST_FIN  = 4'b1000
   } state_type;

endpackage

// File: rtl/pcmp_req_if.sv
// request channel: valid/ready handshake carrying the restart flag
// no dependencies
interface pcmp_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

// File: rtl/pcmp_rsp_if.sv
// result channel: valid/ready handshake carrying index, value and past_end
// depends on pcmp_pkg
interface pcmp_rsp_if
   import pcmp_pkg::*;
;
   logic              valid;
   logic              ready;
   logic [IDX_W-1:0]  index;
   logic [DATA_W-1:0] value;
   logic              past_end;

   modport source (output valid, output index, output value, output past_end, input ready);
   modport sink   (input valid, input index, input value, input past_end, output ready);
endinterface

// File: rtl/partition_count_mod_pentagonal.sv
// partition numbers modulo a configured modulus, euler pentagonal recurrence
// depends on pcmp_pkg, pcmp_req_if, pcmp_rsp_if
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+------------------------------------
//  req_ch   | in  | valid / ready      | restart
//  rsp_ch   | out | valid / ready      | index[9:0], value[31:0], past_end
//  csr_*    | in  | csr_we, no wait    | csr_index[0], csr_wdata[31:0]
//
//  an entry p(n) sums T table entries, T being the number of pentagonal
//  offsets not above n (51 at n = 1023): one table read per offset through
//  the single read port of the value table
//  a stored entry not below the modulus first goes through bit-serial reduction
//  a request past the end skips the summing; one request is worked at a time
//  synchronous reset, no clearing pass; a waiting result does not block the
//  next request from being taken
module partition_count_mod_pentagonal
   import pcmp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   pcmp_req_if.sink             req_ch,
   pcmp_rsp_if.source           rsp_ch,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata
);

   state_type          state_ff, state_in;
   logic [DATA_W-1:0]  modulus_ff, modulus_in;
   logic [LEN_W-1:0]   table_length_ff, table_length_in;
   logic [CNT_W-1:0]   next_index_ff, next_index_in;
   logic [CNT_W-1:0]   n_ff, n_in;
   logic [OFS_W-1:0]   g_ff, g_in;
   logic [KK_W-1:0]    kk_ff, kk_in;
   logic [1:0]         jph_ff, jph_in;
   logic               rd_valid_ff, rd_valid_in;
   logic               rd_neg_ff, rd_neg_in;
   logic [DATA_W-1:0]  mem_q_ff;
   logic [DATA_W-1:0]  acc_ff, acc_in;
   logic [DATA_W-1:0]  rem_ff, rem_in;
   logic [DATA_W-1:0]  div_ff, div_in;
   logic               rem_neg_ff, rem_neg_in;
   logic               rem_ready_ff, rem_ready_in;
   logic [REM_CNT_W-1:0] rem_cnt_ff, rem_cnt_in;
   logic               past_ff, past_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]   rsp_index_ff, rsp_index_in;
   logic [DATA_W-1:0]  rsp_value_ff, rsp_value_in;
   logic               rsp_past_ff, rsp_past_in;

   logic [DATA_W-1:0]  value_mem [TABLE_DEPTH];

   logic [DATA_W-1:0]  m_eff;
   logic [LEN_W-1:0]   eff_len;
   logic [CNT_W-1:0]   req_n;
   logic               in_range;
   logic               stall;
   logic               issue;
   logic [ADDR_W-1:0]  rd_addr;
   logic               slot_free;
   logic               wr_en;
   logic [DATA_W:0]    rem_shift;

   function automatic logic [DATA_W-1:0] mod_acc(
      input logic [DATA_W-1:0] acc,
      input logic [DATA_W-1:0] t,
      input logic              neg,
      input logic [DATA_W-1:0] m
   );
      logic [DATA_W:0] sum;
      logic [DATA_W:0] res;
      sum = {1'b0, acc} + {1'b0, t};
      if (!neg) begin
         res = (sum >= {1'b0, m}) ? sum - {1'b0, m} : sum;
      end else if (acc >= t) begin
         res = {1'b0, acc} - {1'b0, t};
      end else begin
         res = {1'b0, acc} + {1'b0, m} - {1'b0, t};
      end
      return res[DATA_W-1:0];
   endfunction

   assign m_eff     = (modulus_ff == '0) ? DEFAULT_MODULUS : modulus_ff;
   assign eff_len   = (table_length_ff > LEN_W'(TABLE_DEPTH)) ? LEN_W'(TABLE_DEPTH)
                                                             : table_length_ff;
   assign req_n     = req_ch.restart ? '0 : next_index_ff;
   assign in_range  = {{(OFS_W-CNT_W){1'b0}}, req_n} < OFS_W'(eff_len);
   assign stall     = rd_valid_ff && (mem_q_ff >= m_eff);
   assign issue     = (state_ff == ST_RUN) && (g_ff <= {1'b0, n_ff}) && !stall;
   assign rd_addr   = ADDR_W'(n_ff - g_ff[CNT_W-1:0]);
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign wr_en     = (state_ff == ST_FIN) && slot_free && !past_ff;
   assign rem_shift = {rem_ff, div_ff[DATA_W-1]};

   assign req_ch.ready    = (state_ff == ST_IDLE);
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.index    = rsp_index_ff;
   assign rsp_ch.value    = rsp_value_ff;
   assign rsp_ch.past_end = rsp_past_ff;

   // value table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         value_mem[n_ff[ADDR_W-1:0]] <= acc_ff;
      end
      if (issue) begin
         mem_q_ff <= value_mem[rd_addr];
      end
   end

   always_comb begin
      state_in        = state_ff;
      modulus_in      = modulus_ff;
      table_length_in = table_length_ff;
      next_index_in   = next_index_ff;
      n_in            = n_ff;
      g_in            = g_ff;
      kk_in           = kk_ff;
      jph_in          = jph_ff;
      rd_valid_in     = 1'b0;
      rd_neg_in       = rd_neg_ff;
      acc_in          = acc_ff;
      rem_in          = rem_ff;
      div_in          = div_ff;
      rem_neg_in      = rem_neg_ff;
      rem_ready_in    = rem_ready_ff;
      rem_cnt_in      = rem_cnt_ff;
      past_in         = past_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ch.ready;
      rsp_index_in    = rsp_index_ff;
      rsp_value_in    = rsp_value_ff;
      rsp_past_in     = rsp_past_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_MODULUS:      modulus_in      = csr_wdata;
            CSR_TABLE_LENGTH: table_length_in = csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               n_in   = req_n;
               g_in   = OFS_W'(1);
               kk_in  = KK_W'(1);
               jph_in = '0;
               if (in_range) begin
                  next_index_in = req_n + CNT_W'(1);
                  acc_in   = (req_n == '0 && m_eff != DATA_W'(1)) ? DATA_W'(1) : '0;
                  past_in  = 1'b0;
                  state_in = ST_RUN;
               end else begin
                  next_index_in = req_n;
                  past_in  = 1'b1;
                  state_in = ST_FIN;
               end
            end
         end
         ST_RUN: begin
            if (issue) begin
               rd_valid_in = 1'b1;
               rd_neg_in   = jph_ff[1];
               jph_in      = jph_ff + 2'd1;
               if (!jph_ff[0]) begin
                  g_in = g_ff + OFS_W'(kk_ff);
               end else begin
                  g_in  = g_ff + OFS_W'({kk_ff, 1'b1});
                  kk_in = kk_ff + KK_W'(1);
               end
            end
            if (rem_ready_ff) begin
               acc_in       = mod_acc(acc_ff, rem_ff, rem_neg_ff, m_eff);
               rem_ready_in = 1'b0;
            end else if (rd_valid_ff) begin
               if (stall) begin
                  rem_in     = '0;
                  div_in     = mem_q_ff;
                  rem_neg_in = rd_neg_ff;
                  rem_cnt_in = '0;
                  state_in   = ST_REM;
               end else begin
                  acc_in = mod_acc(acc_ff, mem_q_ff, rd_neg_ff, m_eff);
               end
            end else if (g_ff > {1'b0, n_ff}) begin
               state_in = ST_FIN;
            end
         end
         ST_REM: begin
            // restoring remainder, one dividend bit per cycle
            rem_in     = (rem_shift >= {1'b0, m_eff}) ? DATA_W'(rem_shift - {1'b0, m_eff})
                                                      : rem_shift[DATA_W-1:0];
            div_in     = {div_ff[DATA_W-2:0], 1'b0};
            rem_cnt_in = rem_cnt_ff + REM_CNT_W'(1);
            if (rem_cnt_ff == REM_CNT_W'(DATA_W - 1)) begin
               rem_ready_in = 1'b1;
               state_in     = ST_RUN;
            end
         end
         ST_FIN: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = n_ff[IDX_W-1:0];
               rsp_value_in = past_ff ? '0 : acc_ff;
               rsp_past_in  = past_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         modulus_ff      <= '0;
         table_length_ff <= TABLE_LENGTH_RESET;
         next_index_ff   <= '0;
         rd_valid_ff     <= 1'b0;
         rem_ready_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         modulus_ff      <= modulus_in;
         table_length_ff <= table_length_in;
         next_index_ff   <= next_index_in;
         rd_valid_ff     <= rd_valid_in;
         rem_ready_ff    <= rem_ready_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      g_ff         <= g_in;
      kk_ff        <= kk_in;
      jph_ff       <= jph_in;
      rd_neg_ff    <= rd_neg_in;
      acc_ff       <= acc_in;
      rem_ff       <= rem_in;
      div_ff       <= div_in;
      rem_neg_ff   <= rem_neg_in;
      rem_cnt_ff   <= rem_cnt_in;
      past_ff      <= past_in;
      rsp_index_ff <= rsp_index_in;
      rsp_value_ff <= rsp_value_in;
      rsp_past_ff  <= rsp_past_in;
   end

   // running total stays reduced while terms are summed
   a_acc_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (acc_ff < m_eff))
      else $error("running total not reduced");

   // no table read is in flight while the remainder unit runs
   a_rem_no_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REM) |-> (!rd_valid_ff && !issue))
      else $error("table read during remainder");

   // a past-end result carries a zero value
   a_past_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_past_ff) |-> (rsp_value_ff == '0))
      else $error("past-end result with nonzero value");

   // the table is written only when its entry leaves as a result
   a_write_rsp: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (rsp_valid_ff && !rsp_past_ff && rsp_value_ff == $past(acc_ff)))
      else $error("table write without matching result");

endmodule
